// ===== src/arm_pkg.sv =====
// Package for the address region map table.
// Holds the stored entry type, the compare result type and the status codes.
// Used by arm_cmp, arm_store and address_region_map_table.
package arm_pkg;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADLEN = 2'd2;

  localparam logic [4:0] RESERVED_KIND = 5'd16;
  localparam logic [2:0] RIGHTS_NONE   = 3'd0;

  localparam logic OP_MAP    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] length;
    logic [63:0] end_addr;
    logic [4:0]  kind;
    logic [2:0]  rights;
  } entry_t;

  typedef struct packed {
    logic disjoint;
    logic covered;
    logic contains;
    logic left_part;
    logic hit;
  } cls_t;

endpackage

// ===== src/arm_cmp.sv =====
// Shared compare unit of the address region map table.
// Classifies one stored region against the new region and the probe address.
// Depends on arm_pkg.
module arm_cmp (
  input  arm_pkg::entry_t entry,
  input  logic [63:0]     new_base,
  input  logic [63:0]     new_end,
  input  logic [63:0]     probe,
  output arm_pkg::cls_t   cls,
  output logic [63:0]     left_len,
  output logic [63:0]     right_len
);
  import arm_pkg::*;

  always_comb begin
    cls.disjoint  = (entry.end_addr < new_base) || (entry.base > new_end);
    cls.covered   = (entry.base >= new_base) && (entry.end_addr <= new_end);
    cls.contains  = (entry.base < new_base) && (entry.end_addr > new_end);
    cls.left_part = entry.base < new_base;
    cls.hit       = (probe >= entry.base) && (probe <= entry.end_addr);
    left_len      = new_base - entry.base;
    right_len     = entry.end_addr - new_end;
  end

endmodule

// ===== src/arm_store.sv =====
// Region storage of the address region map table.
// One memory of entries with a registered read port, plus flip-flop valid bits.
// Depends on arm_pkg.
module arm_store #(
  parameter int Depth = 32,
  parameter int Iw    = 5
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [Iw-1:0]   rd_addr,
  output arm_pkg::entry_t rd_data,
  output logic            rd_valid,
  input  logic            wr_en,
  input  logic [Iw-1:0]   wr_addr,
  input  arm_pkg::entry_t wr_data,
  input  logic            vset,
  input  logic            vclr
);
  import arm_pkg::*;

  entry_t           mem [Depth];
  logic [Depth-1:0] valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= valid[rd_addr];
      if (vset) begin
        valid[wr_addr] <= 1'b1;
      end else if (vclr) begin
        valid[wr_addr] <= 1'b0;
      end
    end
  end

endmodule

// ===== src/address_region_map_table.sv =====
// Top level of the address region map table.
// Holds the sequencer and the result register; uses arm_store and arm_cmp.
// Depends on arm_pkg.
//
// Usage: one input channel (in_valid/in_ready) carries map and lookup items,
// one output channel (out_valid/out_ready) returns exactly one result per item.
// A map item is checked for length, then the table is walked twice, one entry
// per cycle through the single compare unit: a counting pass decides whether
// the map fits, a second pass trims, removes or splits stored regions, and the
// write states S_STORE_R (only when a region is split) and S_STORE_N store the
// split right piece and the new region. A lookup walks the table once. Each
// walk reads the entries in turn through the one read port of the region memory.
// A lookup passes S_SCAN1 only; a map passes S_SETUP, S_PREP, S_SCAN1, S_DECIDE,
// S_SCAN2 and the write states, and stops in S_DECIDE when the table is full and
// in S_SETUP for a rejected length. The next item can be accepted once the result
// of the previous one has entered the output register.
// in_ready is high only while no item is in work and no finished result waits.
// When the receiver stalls, the output register holds; the next item is
// accepted meanwhile, but its result waits until the previous transfer completes.
// Reset empties the table at once and drops any pending result.
module address_region_map_table #(
  parameter int MAX_REGIONS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [63:0] base_addr,
  input  logic [63:0] length,
  input  logic [4:0]  region_kind,
  input  logic [2:0]  access_rights,
  input  logic [63:0] probe_addr,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        hit,
  output logic [63:0] hit_base,
  output logic [63:0] hit_length,
  output logic [4:0]  hit_kind,
  output logic [2:0]  hit_rights
);
  import arm_pkg::*;

  localparam int Iw = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int Cw = Iw + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_PREP, S_SCAN1, S_DECIDE, S_SCAN2, S_STORE_R, S_STORE_N
  } state_t;

  state_t state;
  logic   fin;

  logic        op;
  logic [63:0] nb, len_r, nbm1, ne, ne_p1, probe, c_end;
  logic [4:0]  kind_r, c_kind;
  logic [2:0]  rights_r, c_rights;
  logic [1:0]  st_r;
  logic        found, have_c, ev, f0_ok, f1_ok;
  entry_t      fe;
  logic [Iw:0]   scnt;
  logic [Iw-1:0] ev_idx, f0, f1;
  logic [Cw-1:0] count, removed, splits;

  logic [Iw-1:0] rd_addr, wr_addr;
  entry_t        rd_data, wr_data;
  logic          rd_valid, wr_en, vset, vclr;
  cls_t          cls;
  logic [63:0]   left_len, right_len;
  logic [64:0]   sum;
  logic          last, scanning;

  assign rd_addr  = (scnt < (Iw + 1)'(MAX_REGIONS)) ? scnt[Iw-1:0] : '0;
  assign in_ready = (state == S_IDLE) && !fin;
  assign sum      = {1'b0, nb} + {1'b0, len_r};
  assign last     = ev && (ev_idx == Iw'(MAX_REGIONS - 1));
  assign scanning = (state == S_SCAN1) || (state == S_SCAN2);

  arm_store #(.Depth(MAX_REGIONS), .Iw(Iw)) u_store (
    .clk, .rst, .rd_addr, .rd_data, .rd_valid, .wr_en, .wr_addr, .wr_data, .vset, .vclr
  );

  arm_cmp u_cmp (
    .entry(rd_data), .new_base(nb), .new_end(ne), .probe(probe),
    .cls, .left_len, .right_len
  );

  always_comb begin
    wr_en   = 1'b0;
    vset    = 1'b0;
    vclr    = 1'b0;
    wr_addr = ev_idx;
    wr_data = rd_data;
    case (state)
      S_SCAN2: begin
        if (ev && rd_valid && !cls.disjoint) begin
          if (cls.covered) begin
            vclr = 1'b1;
          end else if (cls.left_part) begin
            wr_en            = 1'b1;
            wr_data.length   = left_len;
            wr_data.end_addr = nbm1;
          end else begin
            wr_en          = 1'b1;
            wr_data.base   = ne_p1;
            wr_data.length = right_len;
          end
        end
      end
      S_STORE_R: begin
        wr_en   = 1'b1;
        vset    = 1'b1;
        wr_addr = f0;
        wr_data = '{base: ne_p1, length: c_end - ne, end_addr: c_end,
                    kind: c_kind, rights: c_rights};
      end
      S_STORE_N: begin
        wr_en   = 1'b1;
        vset    = 1'b1;
        wr_addr = have_c ? f1 : f0;
        wr_data = '{base: nb, length: len_r, end_addr: ne,
                    kind: kind_r, rights: rights_r};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fin       <= 1'b0;
      out_valid <= 1'b0;
      ev        <= 1'b0;
      scnt      <= '0;
    end else begin
      if (fin && (!out_valid || out_ready)) begin
        fin        <= 1'b0;
        out_valid  <= 1'b1;
        status     <= st_r;
        hit        <= found;
        hit_base   <= found ? fe.base : 64'd0;
        hit_length <= found ? fe.length : 64'd0;
        hit_kind   <= found ? fe.kind : RESERVED_KIND;
        hit_rights <= found ? fe.rights : RIGHTS_NONE;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (scanning) begin
        if (scnt < (Iw + 1)'(MAX_REGIONS)) begin
          scnt   <= scnt + 1'b1;
          ev     <= 1'b1;
          ev_idx <= scnt[Iw-1:0];
        end else begin
          ev <= 1'b0;
        end
      end

      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op       <= opcode;
            nb       <= base_addr;
            len_r    <= length;
            kind_r   <= region_kind;
            rights_r <= access_rights;
            probe    <= probe_addr;
            st_r     <= ST_OK;
            found    <= 1'b0;
            have_c   <= 1'b0;
            count    <= '0;
            removed  <= '0;
            splits   <= '0;
            scnt     <= '0;
            ev       <= 1'b0;
            state    <= (opcode == OP_LOOKUP) ? S_SCAN1 : S_SETUP;
          end
        end
        S_SETUP: begin
          nbm1  <= nb - 64'd1;
          ne_p1 <= sum[63:0];
          if (len_r == 64'd0 || (sum[64] && sum[63:0] != 64'd0)) begin
            st_r  <= ST_BADLEN;
            fin   <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          ne    <= ne_p1 - 64'd1;
          state <= S_SCAN1;
        end
        S_SCAN1: begin
          if (ev && rd_valid) begin
            if (op == OP_LOOKUP) begin
              if (cls.hit && !found) begin
                found <= 1'b1;
                fe    <= rd_data;
              end
            end else begin
              count <= count + 1'b1;
              if (!cls.disjoint && cls.covered) begin
                removed <= removed + 1'b1;
              end else if (!cls.disjoint && cls.contains) begin
                splits   <= splits + 1'b1;
                have_c   <= 1'b1;
                c_end    <= rd_data.end_addr;
                c_kind   <= rd_data.kind;
                c_rights <= rd_data.rights;
              end
            end
          end
          if (last) begin
            if (op == OP_LOOKUP) begin
              fin   <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_DECIDE;
            end
          end
        end
        S_DECIDE: begin
          scnt  <= '0;
          ev    <= 1'b0;
          f0_ok <= 1'b0;
          f1_ok <= 1'b0;
          if (count + splits + 1'b1 > Cw'(MAX_REGIONS) + removed) begin
            st_r  <= ST_FULL;
            fin   <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_SCAN2;
          end
        end
        S_SCAN2: begin
          if (ev && (!rd_valid || (!cls.disjoint && cls.covered))) begin
            if (!f0_ok) begin
              f0    <= ev_idx;
              f0_ok <= 1'b1;
            end else if (!f1_ok) begin
              f1    <= ev_idx;
              f1_ok <= 1'b1;
            end
          end
          if (last) begin
            state <= have_c ? S_STORE_R : S_STORE_N;
          end
        end
        S_STORE_R: begin
          state <= S_STORE_N;
        end
        S_STORE_N: begin
          fin   <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== bench/region_map_checker.sv =====
// Checker for the address region map table: watches both channels, predicts each
// result from its own copy of the region table and compares field by field.
// Depends on arm_pkg for the status codes and the miss values.
`timescale 1ns / 1ps

module region_map_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        opcode,
  input  logic [63:0] base_addr,
  input  logic [63:0] length,
  input  logic [4:0]  region_kind,
  input  logic [2:0]  access_rights,
  input  logic [63:0] probe_addr,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [1:0]  status,
  input  logic        hit,
  input  logic [63:0] hit_base,
  input  logic [63:0] hit_length,
  input  logic [4:0]  hit_kind,
  input  logic [2:0]  hit_rights,
  output int          errors,
  output int          pending
);
  import arm_pkg::*;

  localparam int TABLE_SIZE = 32;

  typedef struct {
    logic [63:0] base;
    logic [63:0] len;
    logic [4:0]  kind;
    logic [2:0]  rights;
  } region_t;

  typedef struct {
    logic [1:0]  status;
    logic        hit;
    logic [63:0] base;
    logic [63:0] len;
    logic [4:0]  kind;
    logic [2:0]  rights;
  } answer_t;

  region_t regions[$];
  answer_t answers[$];

  function automatic answer_t map_region(logic [63:0] nb, logic [63:0] len, logic [4:0] kind,
                                         logic [2:0] rights);
    answer_t a;
    region_t kept[$];
    region_t r;
    region_t piece;
    logic [63:0] ne;
    logic [63:0] me;
    int removed;
    int splits;
    a = '{ST_OK, 1'b0, 64'd0, 64'd0, RESERVED_KIND, RIGHTS_NONE};
    removed = 0;
    splits = 0;
    if (len == 64'd0 || (len - 64'd1) > ~nb) begin
      a.status = ST_BADLEN;
      return a;
    end
    ne = nb + (len - 64'd1);
    foreach (regions[i]) begin
      me = regions[i].base + (regions[i].len - 64'd1);
      if (me < nb || regions[i].base > ne) continue;
      if (regions[i].base >= nb && me <= ne) removed++;
      else if (regions[i].base < nb && me > ne) splits++;
    end
    if (regions.size() - removed + splits + 1 > TABLE_SIZE) begin
      a.status = ST_FULL;
      return a;
    end
    foreach (regions[i]) begin
      r = regions[i];
      me = r.base + (r.len - 64'd1);
      if (me < nb || r.base > ne) begin
        kept.push_back(r);
      end else if (r.base >= nb && me <= ne) begin
        continue;
      end else if (r.base < nb && me > ne) begin
        piece = r;
        piece.len = nb - r.base;
        kept.push_back(piece);
        piece.base = ne + 64'd1;
        piece.len = me - ne;
        kept.push_back(piece);
      end else if (r.base < nb) begin
        r.len = nb - r.base;
        kept.push_back(r);
      end else begin
        r.base = ne + 64'd1;
        r.len = me - ne;
        kept.push_back(r);
      end
    end
    kept.push_back('{nb, len, kind, rights});
    regions = kept;
    return a;
  endfunction

  function automatic answer_t find_region(logic [63:0] probe);
    answer_t a;
    a = '{ST_OK, 1'b0, 64'd0, 64'd0, RESERVED_KIND, RIGHTS_NONE};
    foreach (regions[i]) begin
      if (probe >= regions[i].base && probe - regions[i].base < regions[i].len) begin
        a.hit = 1'b1;
        a.base = regions[i].base;
        a.len = regions[i].len;
        a.kind = regions[i].kind;
        a.rights = regions[i].rights;
      end
    end
    return a;
  endfunction

  assign pending = answers.size();

  always @(posedge clk) begin
    answer_t want;
    if (rst) begin
      regions.delete();
      answers.delete();
      errors <= 0;
    end else begin
      if (in_valid && in_ready) begin
        if (opcode == OP_MAP) answers.push_back(map_region(base_addr, length, region_kind,
                                                           access_rights));
        else answers.push_back(find_region(probe_addr));
      end
      if (out_valid && out_ready) begin
        if (answers.size() == 0) begin
          if (errors < 10) $display("ERROR: transfer out with no result pending");
          errors <= errors + 1;
        end else begin
          want = answers.pop_front();
          if (status !== want.status || hit !== want.hit || hit_base !== want.base ||
              hit_length !== want.len || hit_kind !== want.kind ||
              hit_rights !== want.rights) begin
            if (errors < 10) begin
              $display("ERROR: expected st=%0d hit=%0d base=%h len=%h kind=%0d rights=%0d",
                       want.status, want.hit, want.base, want.len, want.kind, want.rights);
              $display("       actual   st=%0d hit=%0d base=%h len=%h kind=%0d rights=%0d",
                       status, hit, hit_base, hit_length, hit_kind, hit_rights);
            end
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Top of the address region map table bench: clock, reset, stimulus and verdict.
// Instantiates address_region_map_table and region_map_checker; uses arm_pkg.
`timescale 1ns / 1ps

module tb_top;
  import arm_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        opcode;
  logic [63:0] base_addr;
  logic [63:0] length;
  logic [4:0]  region_kind;
  logic [2:0]  access_rights;
  logic [63:0] probe_addr;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic        hit;
  logic [63:0] hit_base;
  logic [63:0] hit_length;
  logic [4:0]  hit_kind;
  logic [2:0]  hit_rights;
  int          errors;
  int          pending;
  bit          steady;
  bit          hold_req;

  address_region_map_table dut (.*);
  region_map_checker chk (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    bit held;
    held = 1'b0;
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 30);
      end
    end
  end

  task automatic send(logic op, logic [63:0] b, logic [63:0] len, logic [4:0] k,
                      logic [2:0] r, logic [63:0] p);
    if (!steady && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    base_addr <= b;
    length <= len;
    region_kind <= k;
    access_rights <= r;
    probe_addr <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic map(logic [63:0] b, logic [63:0] len);
    send(OP_MAP, b, len, 5'($urandom), 3'($urandom), {$urandom, $urandom});
  endtask

  task automatic probe(logic [63:0] p);
    send(OP_LOOKUP, {$urandom, $urandom}, {$urandom, $urandom}, 5'($urandom),
         3'($urandom), p);
  endtask

  initial begin
    logic [63:0] win;
    logic [63:0] top;
    int pick;
    top = '1;
    steady = 1'b0;
    hold_req = 1'b0;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = OP_MAP;
    base_addr = '0;
    length = '0;
    region_kind = '0;
    access_rights = '0;
    probe_addr = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    probe(64'd0);
    map(64'd50, 64'd0);
    map(top - 64'd15, 64'd17);
    map(top - 64'd15, 64'd16);
    probe(top);
    map(64'd0, 64'd1);
    probe(64'd0);
    map(64'd100, 64'd100);
    map(64'd150, 64'd10);
    probe(64'd120);
    probe(64'd155);
    probe(64'd170);
    map(64'd199, 64'd5);
    map(64'd95, 64'd6);
    probe(64'd199);
    probe(64'd100);
    probe(64'd198);
    map(64'd90, 64'd200);
    probe(64'd150);
    map(64'd1, top);
    probe(top);
    probe(64'd0);

    win = 64'd0;
    for (int n = 0; n < 1400; n++) begin
      if (n % 200 == 0) begin
        win = ($urandom_range(3) == 0) ? top - 64'd16383 : {$urandom, 19'($urandom), 13'd0};
        map(win, 64'd16384);
        for (int i = 0; i < 34; i++) map(win + i * 32, 64'($urandom_range(24, 1)));
      end
      steady = (n >= 600 && n < 900);
      if (n == 400) hold_req = 1'b1;
      if (n == 1000) begin
        in_valid <= 1'b0;
        wait (pending == 0);
        @(posedge clk);
      end
      pick = $urandom_range(99);
      if (pick < 45) map(win + $urandom_range(4095), 64'($urandom_range(32, 1)));
      else if (pick < 49) map(win + $urandom_range(4095), 64'($urandom_range(600, 1)));
      else if (pick < 53) map({$urandom, $urandom}, {$urandom, $urandom});
      else if (pick < 55) map(win + $urandom_range(4095), 64'd0);
      else if (pick < 57) map(win, 64'd4096 + $urandom_range(64));
      else if (pick < 92) probe(win + $urandom_range(4200));
      else probe({$urandom, $urandom});
    end
    in_valid <= 1'b0;
    steady = 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
